FILE: rtl/core/ipid_pkg.sv
package ipid_pkg;

    // Fraction bits of the Q8.8 gains; each product is shifted down by this much.
    localparam int unsigned FRAC_BITS = 8;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned ERR_W   = DATA_W + 1;
    localparam int unsigned PDIFF_W = ERR_W + 1;
    localparam int unsigned DDIFF_W = ERR_W + 2;
    localparam int unsigned PROD_P_W = DATA_W + PDIFF_W;
    localparam int unsigned PROD_I_W = DATA_W + ERR_W;
    localparam int unsigned PROD_D_W = DATA_W + DDIFF_W;
    localparam int unsigned SUM_W    = PROD_D_W + 2;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        REG_SETPOINT = 2'd0,
        REG_GAIN_P   = 2'd1,
        REG_GAIN_I   = 2'd2,
        REG_GAIN_D   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
    } t_cfg;

endpackage

FILE: rtl/core/ipid_cfg_regs.sv
module ipid_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipid_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ipid_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ipid_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ipid_pkg::t_cfg                    o_cfg
);
    import ipid_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic [DATA_W-1:0] w_rd;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SETPOINT: r_cfg.setpoint <= pwdata[DATA_W-1:0];
                REG_GAIN_P:   r_cfg.gain_p   <= pwdata[DATA_W-1:0];
                REG_GAIN_I:   r_cfg.gain_i   <= pwdata[DATA_W-1:0];
                REG_GAIN_D:   r_cfg.gain_d   <= pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SETPOINT: w_rd = r_cfg.setpoint;
            REG_GAIN_P:   w_rd = r_cfg.gain_p;
            REG_GAIN_I:   w_rd = r_cfg.gain_i;
            REG_GAIN_D:   w_rd = r_cfg.gain_d;
        endcase
    end

    // Registers are read back sign-extended to the bus width.
    assign prdata = {{(APB_DATA_W-DATA_W){w_rd[DATA_W-1]}}, w_rd};
    assign o_cfg  = r_cfg;

endmodule

FILE: rtl/core/ipid_core.sv
module ipid_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic                             i_kind,
    input  logic signed [ipid_pkg::DATA_W-1:0] i_measurement,
    input  ipid_pkg::t_cfg                   i_cfg,
    output logic signed [ipid_pkg::DATA_W-1:0] o_drive,
    output logic                             o_saturated
);
    import ipid_pkg::*;

    logic signed [ERR_W-1:0]    r_prev_error;
    logic signed [ERR_W-1:0]    r_prev_prev_error;
    logic signed [DATA_W-1:0]   r_prev_drive;

    logic signed [ERR_W-1:0]    w_err;
    logic signed [PDIFF_W-1:0]  w_pdiff;
    logic signed [DDIFF_W-1:0]  w_ddiff;
    logic signed [PROD_P_W-1:0] w_prod_p;
    logic signed [PROD_I_W-1:0] w_prod_i;
    logic signed [PROD_D_W-1:0] w_prod_d;
    logic signed [PROD_P_W-1:0] w_term_p;
    logic signed [PROD_I_W-1:0] w_term_i;
    logic signed [PROD_D_W-1:0] w_term_d;
    logic signed [SUM_W-1:0]    w_sum;
    logic                       w_ovf;
    logic signed [DATA_W-1:0]   w_clamped;

    assign w_err   = {i_measurement[DATA_W-1], i_measurement}
                   - {i_cfg.setpoint[DATA_W-1], i_cfg.setpoint};
    assign w_pdiff = {w_err[ERR_W-1], w_err} - {r_prev_error[ERR_W-1], r_prev_error};
    assign w_ddiff = {{2{w_err[ERR_W-1]}}, w_err}
                   - {r_prev_error[ERR_W-1], r_prev_error, 1'b0}
                   + {{2{r_prev_prev_error[ERR_W-1]}}, r_prev_prev_error};

    assign w_prod_p = $signed(i_cfg.gain_p) * w_pdiff;
    assign w_prod_i = $signed(i_cfg.gain_i) * r_prev_error;
    assign w_prod_d = $signed(i_cfg.gain_d) * w_ddiff;

    // Arithmetic shifts round toward minus infinity.
    assign w_term_p = w_prod_p >>> FRAC_BITS;
    assign w_term_i = w_prod_i >>> FRAC_BITS;
    assign w_term_d = w_prod_d >>> FRAC_BITS;

    assign w_sum = SUM_W'(r_prev_drive) + SUM_W'(w_term_p)
                 + SUM_W'(w_term_i) + SUM_W'(w_term_d);

    // The sum fits 16 bits only when every bit above bit 15 matches the sign.
    assign w_ovf = (w_sum[SUM_W-1:DATA_W-1] != '0) && (w_sum[SUM_W-1:DATA_W-1] != '1);

    always_comb begin
        if (!w_ovf) begin
            w_clamped = w_sum[DATA_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_clamped = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_clamped = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        if (i_kind == KIND_CLEAR) begin
            o_drive     = '0;
            o_saturated = 1'b0;
        end else begin
            o_drive     = w_clamped;
            o_saturated = w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error      <= '0;
            r_prev_prev_error <= '0;
            r_prev_drive      <= '0;
        end else if (i_fire) begin
            if (i_kind == KIND_CLEAR) begin
                r_prev_error      <= '0;
                r_prev_prev_error <= '0;
                r_prev_drive      <= '0;
            end else begin
                r_prev_error      <= w_err;
                r_prev_prev_error <= r_prev_error;
                r_prev_drive      <= w_clamped;
            end
        end
    end

endmodule

FILE: rtl/core/incremental_pid_step.sv
// An accepted input transaction waits in the input registers; its result is registered at the outputs.
// Throughput: one transaction per cycle while the output is not stalled, set by the loop from the error history
// and previous drive registers through the three gain multipliers and the sum back to them.
// Reset (synchronous, active low) clears the gains, setpoint, error history, previous
// drive and both valid flags; input and result payload registers are not reset.
module incremental_pid_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipid_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ipid_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ipid_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic signed [ipid_pkg::DATA_W-1:0] i_measurement,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ipid_pkg::DATA_W-1:0] o_drive,
    output logic                              o_saturated
);
    import ipid_pkg::*;

    t_cfg                     w_cfg;
    logic                     r_in_valid;
    logic                     r_in_kind;
    logic signed [DATA_W-1:0] r_in_meas;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_drive;
    logic                     r_out_sat;
    logic                     w_out_ready;
    logic                     w_fire;
    logic                     w_in_take;
    logic signed [DATA_W-1:0] w_drive;
    logic                     w_sat;

    ipid_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ipid_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_kind        (r_in_kind),
        .i_measurement (r_in_meas),
        .i_cfg         (w_cfg),
        .o_drive       (w_drive),
        .o_saturated   (w_sat)
    );

    // The result register can take a new value when empty or being emptied this cycle.
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign w_in_take   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind <= i_kind;
            r_in_meas <= i_measurement;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_drive <= w_drive;
            r_out_sat   <= w_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;
    assign o_saturated = r_out_sat;

    a_clear_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_kind == KIND_CLEAR) |=> (o_out_valid && o_drive == '0 && !o_saturated))
        else $error("clear transaction did not produce a zero result");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_drive == {1'b0, {(DATA_W-1){1'b1}}} || o_drive == {1'b1, {(DATA_W-1){1'b0}}}))
        else $error("saturated flag set but drive is not at a range limit");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the result register could accept");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ipid_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     saturated;
    } t_pid_out;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_kind;
    logic signed [DATA_W-1:0]   i_measurement;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [DATA_W-1:0]   o_drive;
    logic                       o_saturated;

    // Shadow of the controller registers and its error history.
    logic signed [DATA_W-1:0]   sh_setpoint;
    logic signed [DATA_W-1:0]   sh_gain_p;
    logic signed [DATA_W-1:0]   sh_gain_i;
    logic signed [DATA_W-1:0]   sh_gain_d;
    logic signed [ERR_W-1:0]    err_d1;
    logic signed [ERR_W-1:0]    err_d2;
    logic signed [DATA_W-1:0]   drive_d1;

    t_pid_out                   expected_drive_q[$];
    int                         err_count;
    int                         cycle_count;
    int                         send_idle_pct;
    int                         stall_pct;
    bit                         hold_req;
    int                         hold_req_len;
    int                         hold_left;

    incremental_pid_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_measurement (i_measurement),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive       (o_drive),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("** incremental_pid_step: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // Works out one controller step and advances the shadow history.
    function automatic t_pid_out pid_step_predict(input logic kind,
                                                  input logic signed [DATA_W-1:0] meas);
        longint   e;
        longint   e1;
        longint   e2;
        longint   acc;
        t_pid_out res;
        if (kind == KIND_CLEAR) begin
            err_d1   = '0;
            err_d2   = '0;
            drive_d1 = '0;
            res.drive     = '0;
            res.saturated = 1'b0;
            return res;
        end
        e1  = err_d1;
        e2  = err_d2;
        e   = longint'(meas) - longint'(sh_setpoint);
        // Arithmetic shifts of signed products round towards minus infinity.
        acc = longint'(drive_d1)
            + ((longint'(sh_gain_p) * (e - e1)) >>> FRAC_BITS)
            + ((longint'(sh_gain_i) * e1) >>> FRAC_BITS)
            + ((longint'(sh_gain_d) * (e - 2 * e1 + e2)) >>> FRAC_BITS);
        res.saturated = 1'b0;
        if (acc > 32767) begin
            acc = 32767;
            res.saturated = 1'b1;
        end else if (acc < -32768) begin
            acc = -32768;
            res.saturated = 1'b1;
        end
        res.drive = DATA_W'(acc);
        err_d2    = err_d1;
        err_d1    = ERR_W'(e);
        drive_d1  = res.drive;
        return res;
    endfunction

    // Every accepted input transaction yields exactly one expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_drive_q.push_back(pid_step_predict(i_kind, i_measurement));
        end
    end

    always @(posedge i_clk) begin
        t_pid_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_drive_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result drive=%0d saturated=%0b",
                                          o_drive, o_saturated));
            end else begin
                exp_res = expected_drive_q.pop_front();
                if (o_drive !== exp_res.drive) begin
                    report_mismatch($sformatf("drive %0d, expected %0d",
                                              o_drive, exp_res.drive));
                end
                if (o_saturated !== exp_res.saturated) begin
                    report_mismatch($sformatf("saturated %0b, expected %0b",
                                              o_saturated, exp_res.saturated));
                end
            end
        end
    end

    // Result side: random stalls, or a counted hold-off when one is requested.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = hold_req_len;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic cfg_write(input t_reg_idx idx, input logic signed [DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SETPOINT: sh_setpoint = value;
            REG_GAIN_P:   sh_gain_p   = value;
            REG_GAIN_I:   sh_gain_i   = value;
            REG_GAIN_D:   sh_gain_d   = value;
            default: ;
        endcase
        // Read the register back.
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[DATA_W-1:0] !== value) begin
            report_mismatch($sformatf("register %s read %0h, expected %0h",
                                      idx.name(), rd[DATA_W-1:0], value));
        end
    endtask

    task automatic cfg_all(input logic signed [DATA_W-1:0] sp, input logic signed [DATA_W-1:0] kp,
                           input logic signed [DATA_W-1:0] ki, input logic signed [DATA_W-1:0] kd);
        cfg_write(REG_SETPOINT, sp);
        cfg_write(REG_GAIN_P, kp);
        cfg_write(REG_GAIN_I, ki);
        cfg_write(REG_GAIN_D, kd);
    endtask

    task automatic send_item(input logic kind, input logic signed [DATA_W-1:0] meas);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid    <= 1'b0;
            i_kind        <= 1'($urandom);
            i_measurement <= DATA_W'($urandom);
            repeat ($urandom_range(0, 2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_measurement <= meas;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stops offering transactions and waits until every result has come back.
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return DATA_W'($urandom);
            1:       return 16'sh8000;
            2:       return 16'sh7fff;
            default: return DATA_W'(int'($urandom_range(0, 1200)) - 600);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_measurement();
        int t;
        case ($urandom_range(0, 5))
            0, 1: return DATA_W'($urandom);
            2:    return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: begin
                t = int'(sh_setpoint) + int'($urandom_range(0, 512)) - 256;
                return DATA_W'(t);
            end
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(KIND_SAMPLE, 16'sh7fff);
        send_item(KIND_SAMPLE, 16'sh8000);
        send_item(KIND_CLEAR, 16'sh5a5a);
        wait_drain();
    endtask

    task automatic test_gain_extremes();
        cfg_all(16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000);
        send_item(KIND_SAMPLE, 16'sh7fff);
        send_item(KIND_SAMPLE, 16'sh8000);
        send_item(KIND_CLEAR, 16'sh0000);
        wait_drain();
        cfg_all(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(KIND_SAMPLE, 16'sh8000);
        send_item(KIND_SAMPLE, 16'sh8000);
        send_item(KIND_SAMPLE, 16'sh7fff);
        send_item(KIND_SAMPLE, 16'sh0000);
        send_item(KIND_CLEAR, 16'shffff);
        wait_drain();
        cfg_all(16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(KIND_SAMPLE, 16'sh8000);
        send_item(KIND_SAMPLE, 16'sh7fff);
        wait_drain();
    endtask

    // Small gains keep the loop out of saturation, so the history terms show through.
    task automatic test_tracking();
        cfg_all(16'sd100, 16'sd256, 16'sd64, -16'sd32);
        send_item(KIND_SAMPLE, 16'sd90);
        send_item(KIND_SAMPLE, 16'sd95);
        send_item(KIND_SAMPLE, 16'sd105);
        send_item(KIND_SAMPLE, 16'sd100);
        send_item(KIND_SAMPLE, 16'sd0);
        send_item(KIND_CLEAR, 16'sd123);
        send_item(KIND_SAMPLE, 16'sd100);
        send_item(KIND_SAMPLE, 16'sd110);
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        cfg_all(16'sd0, 16'sd300, 16'sd20, 16'sd50);
        hold_req_len = 80;
        hold_req     = 1'b1;
        for (int n = 0; n < 100; n++) begin
            send_item($urandom_range(0, 99) < 5 ? KIND_CLEAR : KIND_SAMPLE, pick_measurement());
        end
        wait_drain();
    endtask

    task automatic test_random_phase(input int idle_p, input int stall_p, input int n_items);
        send_idle_pct = idle_p;
        stall_pct     = stall_p;
        for (int n = 0; n < n_items; n++) begin
            if (n % 150 == 0) begin
                wait_drain();
                cfg_all(pick_gain(), pick_gain(), pick_gain(), pick_gain());
            end else if (n % 50 == 0) begin
                wait_drain();
            end
            send_item($urandom_range(0, 99) < 7 ? KIND_CLEAR : KIND_SAMPLE, pick_measurement());
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_SAMPLE;
        i_measurement = '0;
        err_count     = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        hold_req_len  = 0;
        hold_left     = 0;
        sh_setpoint   = '0;
        sh_gain_p     = '0;
        sh_gain_i     = '0;
        sh_gain_d     = '0;
        err_d1        = '0;
        err_d2        = '0;
        drive_d1      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_gain_extremes();
        test_tracking();
        test_backpressure();
        test_random_phase(0, 0, 455);
        test_random_phase(46, 0, 455);
        test_random_phase(0, 46, 455);
        test_random_phase(33, 33, 455);

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("** incremental_pid_step: PASSED **");
        end else begin
            $display("** incremental_pid_step: FAILED **");
        end
        $finish;
    end

endmodule

FILE: incremental_pid_step.f
rtl/core/ipid_pkg.sv
rtl/core/ipid_cfg_regs.sv
rtl/core/ipid_core.sv
rtl/core/incremental_pid_step.sv
dv/tb_top.sv
